// ===== rtl/mxt_pkg.sv =====
// ============================================================================
// mxt_pkg: shared codes and control types for the max-XOR bit trie
// Operation and status codes, and the command and status groups that run
// between the controller and the datapath.
// ============================================================================
`default_nettype none

package mxt_pkg;

    // operation codes on the mode port
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic       load;        // latch key, start a walk at the root
        logic       restart;     // rewind the walk to the root for the update pass
        logic       scan_step;   // follow the key one level, no writes
        logic       upd_step;    // update one node on the path, allocate if missing
        logic       upd_inc;     // 1: count up (insert), 0: count down (delete)
        logic       leaf_upd;    // update the leaf count
        logic       qry_start;   // fetch both children of the root
        logic       qry_step;    // pick the better child, fetch its children
        logic       finish;      // register a result for one cycle
        logic       fin_result;  // result carries the query partner
        logic [1:0] fin_status;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic child_zero;   // path child on the key bit is missing
        logic last_level;   // walk is at bit 0
        logic pool_short;   // not enough free nodes for the pending insert
        logic leaf_empty;   // leaf reached by the scan holds no copy
        logic root_empty;   // store holds no value
        logic root_full;    // root count saturated
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/mxt_ctrl.sv =====
// ============================================================================
// mxt_ctrl: operation sequencer for the max-XOR bit trie
// Steps an item through its walks (scan, check, update, leaf, or query) and
// tells the datapath when to post the result.
// ============================================================================
`default_nettype none

module mxt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [1:0]     mode,
    input  mxt_pkg::stat_t      stat,
    output logic                busy,
    output mxt_pkg::cmd_t       cmd
);
    import mxt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHK,
        S_UPD,
        S_LEAF,
        S_QRY
    } state_t;

    state_t state_reg, state_next;
    logic   op_ins_reg, op_ins_next;   // 1 for insert, 0 for delete

    // next state and commands
    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        op_ins_next = op_ins_reg;
        cmd.upd_inc = op_ins_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (mode)
                        MODE_INSERT:
                        begin
                            if (stat.root_full)
                            begin
                                cmd.finish     = 1'b1;
                                cmd.fin_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.load    = 1'b1;
                                op_ins_next = 1'b1;
                                state_next  = S_SCAN;
                            end
                        end
                        MODE_DELETE:
                        begin
                            cmd.load    = 1'b1;
                            op_ins_next = 1'b0;
                            state_next  = S_SCAN;
                        end
                        MODE_QUERY:
                        begin
                            if (stat.root_empty)
                            begin
                                cmd.finish     = 1'b1;
                                cmd.fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.load      = 1'b1;
                                cmd.qry_start = 1'b1;
                                state_next    = S_QRY;
                            end
                        end
                        default:
                        begin
                            // unused code: no action, plain ok
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.child_zero)
                begin
                    if (op_ins_reg)
                    begin
                        state_next = S_CHK;
                    end
                    else
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_ABSENT;
                        state_next     = S_IDLE;
                    end
                end
                else if (stat.last_level)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (op_ins_reg ? stat.pool_short : stat.leaf_empty)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = op_ins_reg ? ST_FULL : ST_ABSENT;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.restart = 1'b1;
                    state_next  = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.upd_step = 1'b1;
                if (stat.last_level)
                begin
                    state_next = S_LEAF;
                end
            end
            S_LEAF:
            begin
                cmd.leaf_upd   = 1'b1;
                cmd.finish     = 1'b1;
                cmd.fin_status = ST_OK;
                state_next     = S_IDLE;
            end
            S_QRY:
            begin
                cmd.qry_step = 1'b1;
                if (stat.last_level)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_result = 1'b1;
                    cmd.fin_status = ST_OK;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_ins_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_ins_reg <= op_ins_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/mxt_dp.sv =====
// ============================================================================
// mxt_dp: node store and walk datapath for the max-XOR bit trie
// Root node in flops, other nodes in a one-write two-read memory; walk
// registers, node allocator and the registered result.
// ============================================================================
`default_nettype none

module mxt_dp #(
    parameter int KEY_BITS   = 32,
    parameter int MAX_NODES  = 65536,
    parameter int COUNT_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [31:0]    key_value,
    input  mxt_pkg::cmd_t       cmd,
    output mxt_pkg::stat_t      stat,
    output logic                done,
    output logic [1:0]          status,
    output logic [31:0]         best_partner,
    output logic [31:0]         max_xor
);
    import mxt_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int LVL_W  = $clog2(KEY_BITS + 1);
    localparam int SUM_W  = NODE_W + 2;

    typedef struct packed {
        logic [NODE_W-1:0]     c0;
        logic [NODE_W-1:0]     c1;
        logic [COUNT_BITS-1:0] cnt;
    } node_t;

    // node store; entries at or above the allocation count are never read as data
    node_t mem [MAX_NODES];
    node_t rd_a_reg, rd_b_reg;

    // walk state
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] walk_reg;       // key shifted so the current bit is the MSB
    logic [KEY_BITS-1:0] partner_reg;
    logic [LVL_W-1:0]    lvl_reg;
    logic [LVL_W-1:0]    need_reg;       // nodes an insert must allocate
    logic [NODE_W-1:0]   node_reg;
    logic [NODE_W-1:0]   qc0_reg, qc1_reg;
    logic                at_root_reg;
    logic                fresh_reg;      // current node just allocated, reads as empty
    node_t               root_reg;
    logic [NODE_W:0]     next_free_reg;

    // result
    logic        done_reg;
    logic [1:0]  status_reg;
    logic [31:0] best_partner_reg;
    logic [31:0] max_xor_reg;

    node_t               cur;
    logic                bit_cur;
    logic [NODE_W-1:0]   child;
    logic                child_zero;
    logic                alloc;
    logic [NODE_W-1:0]   new_child;
    node_t               upd_node;
    node_t               leaf_node;
    logic                ok0, ok1, pick;
    node_t               chosen;
    logic [KEY_BITS-1:0] partner_next;
    logic [KEY_BITS-1:0] walk_shift;
    logic                we;
    logic [NODE_W-1:0]   waddr;
    node_t               wdata;
    logic                re_a, re_b;
    logic [NODE_W-1:0]   addr_a, addr_b;

    // current node and the child on the key bit
    always_comb
    begin
        if (at_root_reg)
            cur = root_reg;
        else if (fresh_reg)
            cur = '0;
        else
            cur = rd_a_reg;
        bit_cur    = walk_reg[KEY_BITS-1];
        child      = bit_cur ? cur.c1 : cur.c0;
        child_zero = (child == '0);
        alloc      = cmd.upd_step && child_zero;
        new_child  = alloc ? next_free_reg[NODE_W-1:0] : child;
        walk_shift = walk_reg << 1;
    end

    // path node and leaf updates
    always_comb
    begin
        upd_node     = cur;
        upd_node.cnt = cmd.upd_inc ? cur.cnt + COUNT_BITS'(1) : cur.cnt - COUNT_BITS'(1);
        if (alloc && bit_cur)
            upd_node.c1 = new_child;
        if (alloc && !bit_cur)
            upd_node.c0 = new_child;
        leaf_node     = cur;
        leaf_node.cnt = upd_node.cnt;
    end

    // query choice: opposite bit when that child exists and is not empty
    always_comb
    begin
        ok0          = (qc0_reg != '0) && (rd_a_reg.cnt != '0);
        ok1          = (qc1_reg != '0) && (rd_b_reg.cnt != '0);
        pick         = bit_cur ? !ok0 : ok1;
        chosen       = pick ? rd_b_reg : rd_a_reg;
        partner_next = (partner_reg << 1) | KEY_BITS'(pick);
    end

    // memory port control
    always_comb
    begin
        we     = (cmd.upd_step && !at_root_reg) || cmd.leaf_upd;
        waddr  = node_reg;
        wdata  = cmd.leaf_upd ? leaf_node : upd_node;
        re_a   = (cmd.scan_step && !child_zero) || cmd.upd_step
                 || cmd.qry_start || cmd.qry_step;
        re_b   = cmd.qry_start || cmd.qry_step;
        addr_a = cmd.qry_start ? root_reg.c0 : (cmd.qry_step ? chosen.c0 : new_child);
        addr_b = cmd.qry_start ? root_reg.c1 : chosen.c1;
    end

    // node memory: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re_a)
            rd_a_reg <= mem[addr_a];
        if (re_b)
            rd_b_reg <= mem[addr_b];
    end

    // walk control, root node and allocator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_root_reg   <= 1'b1;
            fresh_reg     <= 1'b0;
            lvl_reg       <= '0;
            root_reg      <= '0;
            next_free_reg <= (NODE_W+1)'(1);
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.load || cmd.restart)
            begin
                at_root_reg <= 1'b1;
                fresh_reg   <= 1'b0;
                lvl_reg     <= LVL_W'(KEY_BITS - 1);
            end
            if (cmd.scan_step && !child_zero)
            begin
                at_root_reg <= 1'b0;
                lvl_reg     <= lvl_reg - LVL_W'(1);
            end
            if (cmd.upd_step)
            begin
                at_root_reg <= 1'b0;
                fresh_reg   <= alloc;
                lvl_reg     <= lvl_reg - LVL_W'(1);
                if (alloc)
                    next_free_reg <= next_free_reg + (NODE_W+1)'(1);
                if (at_root_reg)
                    root_reg <= upd_node;
            end
            if (cmd.qry_step)
                lvl_reg <= lvl_reg - LVL_W'(1);
        end
    end

    // walk payload and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg     <= KEY_BITS'(key_value);
            walk_reg    <= KEY_BITS'(key_value);
            partner_reg <= '0;
            need_reg    <= '0;
        end
        if (cmd.restart)
            walk_reg <= key_reg;
        if (cmd.scan_step)
        begin
            if (child_zero)
                need_reg <= lvl_reg + LVL_W'(1);
            else
            begin
                walk_reg <= walk_shift;
                node_reg <= child;
            end
        end
        if (cmd.upd_step)
        begin
            walk_reg <= walk_shift;
            node_reg <= new_child;
        end
        if (cmd.qry_start)
        begin
            qc0_reg <= root_reg.c0;
            qc1_reg <= root_reg.c1;
        end
        if (cmd.qry_step)
        begin
            walk_reg    <= walk_shift;
            partner_reg <= partner_next;
            qc0_reg     <= chosen.c0;
            qc1_reg     <= chosen.c1;
        end
        if (cmd.finish)
        begin
            status_reg       <= cmd.fin_status;
            best_partner_reg <= cmd.fin_result ? 32'(partner_next) : '0;
            max_xor_reg      <= cmd.fin_result ? 32'(key_reg ^ partner_next) : '0;
        end
    end

    // status to the controller
    always_comb
    begin
        stat.child_zero = child_zero;
        stat.last_level = (lvl_reg == '0);
        stat.pool_short = (SUM_W'(next_free_reg) + SUM_W'(need_reg)) > SUM_W'(MAX_NODES);
        stat.leaf_empty = (rd_a_reg.cnt == '0);
        stat.root_empty = (root_reg.cnt == '0);
        stat.root_full  = &root_reg.cnt;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign best_partner = best_partner_reg;
    assign max_xor      = max_xor_reg;

    // allocator never hands out a node past the pool
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= (NODE_W+1)'(MAX_NODES))
        else $error("node allocator ran past the pool");

    // root lives in flops; the memory copy of node zero is never written
    a_no_root_write: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (waddr != '0))
        else $error("memory write to the root node");

    // counts are consistent, so a query always finds a nonempty child
    a_qry_pick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.qry_step |-> (ok0 || ok1))
        else $error("query step with no nonempty child");

endmodule

`default_nettype wire

// ===== rtl/max_xor_bit_trie.sv =====
// Insert and delete run from start to done through a scan walk, a check state,
// an update walk and a leaf write. Query runs one query walk from the root.
// Absent deletes end in the scan or at the check; pool-full refusals end at the check.
// Saturated-root refusals, empty queries and the unused mode finish from idle.
// One item at a time, the next one taken in the cycle done pulses; no receiver stall.
// Reset clears the root and sets the allocation count to one; no clearing pass, ready at once.
// ============================================================================
// max_xor_bit_trie: binary trie multiset with maximum-XOR query
// Insert, delete and query items over KEY_BITS-bit keys; each item returns
// one status transfer with the best partner and its XOR for queries.
// ============================================================================
`default_nettype none

module max_xor_bit_trie #(
    parameter int KEY_BITS   = 32,
    parameter int MAX_NODES  = 65536,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] key_value,
    output logic             busy,
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      best_partner,
    output logic [31:0]      max_xor
);
    import mxt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    mxt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // node store and walk datapath
    mxt_dp #(
        .KEY_BITS   (KEY_BITS),
        .MAX_NODES  (MAX_NODES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_value    (key_value),
        .cmd          (cmd),
        .stat         (stat),
        .done         (done),
        .status       (status),
        .best_partner (best_partner),
        .max_xor      (max_xor)
    );

    // a result transfer only follows an accepted item or work in progress
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) || $past(busy)))
        else $error("result strobe without an item");

endmodule

`default_nettype wire
